// ===== rtl/pvp_pkg.sv =====
// ----------------------------------------------------------------------------
// pvp_pkg: shared types and constants of the vertex projection block
// Item formats, register indexes and the divider cell data bundles.
// ----------------------------------------------------------------------------
package pvp_pkg;

    // Default fraction bits of positions
    localparam int COORD_FRAC_BITS_DEF = 16;
    // Fraction bits of direction components
    localparam int DIR_FRAC = 14;
    // Quotient bits per ratio term (clamp point is 2^40)
    localparam int QUO_W = 41;
    // Width of raw camera depth and of the divider remainder
    localparam int DEN_W = 50;
    // Width of a signed ratio numerator
    localparam int NUM_W = 62;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_EYE_HEIGHT    = 2'd0;
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_NEAR_LIMIT    = 2'd3;

    // Register reset values
    localparam logic signed [31:0] EYE_HEIGHT_RST    = 32'sd0;
    localparam logic [11:0]        SCREEN_WIDTH_RST  = 12'd320;
    localparam logic [11:0]        SCREEN_HEIGHT_RST = 12'd240;
    localparam logic [30:0]        NEAR_LIMIT_RST    = 31'd6554;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_height;
        logic signed [31:0] vertex_z;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_z;
    } vtx_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic [30:0]        depth;
        logic               visible;
    } res_t;

    // One division lane: partial remainder, unused dividend bits, quotient
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } lane_t;

    // Control and status that ride along the divider chain
    typedef struct packed {
        logic        vis;
        logic [30:0] depth;
        logic        neg_x;
        logic        neg_y;
        logic        ovf_x;
        logic        ovf_y;
    } side_t;

endpackage

// ===== rtl/pvp_div_cell.sv =====
// ----------------------------------------------------------------------------
// pvp_div_cell: one restoring division step for both ratio lanes
// Brings down one dividend bit, subtracts the depth when it fits and
// hands remainder, quotient and sideband to the next cell.
// ----------------------------------------------------------------------------
module pvp_div_cell
    import pvp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [DEN_W-1:0]   in_den,
    input  side_t              in_side,
    input  lane_t [1:0]        in_lane,
    output logic               out_valid,
    output logic [DEN_W-1:0]   out_den,
    output side_t              out_side,
    output lane_t [1:0]        out_lane
);

    logic               valid_reg;
    logic [DEN_W-1:0]   den_reg;
    side_t              side_reg;
    lane_t [1:0]        lane_reg;
    lane_t [1:0]        lane_next;

    function automatic lane_t div_step(input lane_t l, input logic [DEN_W-1:0] d);
        logic [DEN_W:0] cat;
        logic [DEN_W:0] diff;
        logic           ge;
        lane_t          r;
        cat   = {l.rem, l.low[QUO_W-1]};
        diff  = cat - {1'b0, d};
        ge    = (cat >= {1'b0, d});
        r.rem = ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
        r.low = {l.low[QUO_W-2:0], 1'b0};
        r.quo = {l.quo[QUO_W-2:0], ge};
        return r;
    endfunction

    // Step both lanes against the shared divisor
    always_comb
    begin
        lane_next[0] = div_step(in_lane[0], in_den);
        lane_next[1] = div_step(in_lane[1], in_den);
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold the data of the item in flight
    always_ff @(posedge clk)
    begin
        den_reg  <= in_den;
        side_reg <= in_side;
        lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;
    assign out_lane  = lane_reg;

    // Remainder must stay below the divisor in every step
    a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> lane_reg[0].rem < den_reg)
        else $error("x lane remainder not below divisor");
    a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> lane_reg[1].rem < den_reg)
        else $error("y lane remainder not below divisor");
    a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> den_reg != '0)
        else $error("zero divisor in chain");

endmodule

// ===== rtl/perspective_vertex_projection.sv =====
// ----------------------------------------------------------------------------
// Throughput: one vertex item per cycle; busy stays low, results never stall.
// The pipeline holds 5 arithmetic stages, 41 divider cells (one quotient bit
// each) and the output register.
// Reset: clears all valid flags and loads the register reset values.
// ----------------------------------------------------------------------------
// perspective_vertex_projection: vertex to screen projection with near reject
// Rotates an eye-relative vertex into camera space, rejects points at or
// below the near limit and divides through by depth in a chain of cells.
// ----------------------------------------------------------------------------
module perspective_vertex_projection
    import pvp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  vtx_t        vtx,
    output logic        done,
    output res_t        res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int HI_SHIFT = QUO_W - COORD_FRAC_BITS;
    localparam int LAT      = QUO_W + 6;

    // Configuration registers
    logic signed [31:0] eye_height_reg;
    logic [11:0]        screen_width_reg;
    logic [11:0]        screen_height_reg;
    logic [30:0]        near_limit_reg;

    // Stage 1: offsets
    logic               s1_valid_reg;
    logic signed [32:0] dx_reg, dz_reg, dy1_reg;
    logic signed [15:0] ux_reg, uz_reg;
    // Stage 2: products
    logic               s2_valid_reg;
    logic signed [48:0] p_xx_reg, p_xz_reg, p_zx_reg, p_zz_reg;
    logic signed [32:0] dy2_reg;
    // Stage 3: camera x and depth
    logic               s3_valid_reg;
    logic signed [DEN_W-1:0] cx_reg, cz_reg;
    logic signed [32:0] dy3_reg;
    // Stage 4: near test and numerators
    logic               s4_valid_reg;
    logic               vis_reg;
    logic [30:0]        depth_reg;
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic [DEN_W-1:0]   den4_reg;
    // Stage 5: chain entry
    logic               s5_valid_reg;
    logic [DEN_W-1:0]   den5_reg;
    side_t              side5_reg;
    lane_t [1:0]        lane5_reg;

    logic                    vis_next;
    logic [30:0]             depth_next;
    logic signed [45:0]      dysh;
    logic signed [NUM_W-1:0] nx_next, ny_next;
    logic [NUM_W-1:0]        mag_x, mag_y, hi_x, hi_y;
    logic                    ovf_x, ovf_y;
    side_t                   side5_next;
    lane_t [1:0]             lane5_next;

    // Divider chain wiring
    logic                    ch_valid [QUO_W+1];
    logic [DEN_W-1:0]        ch_den   [QUO_W+1];
    side_t                   ch_side  [QUO_W+1];
    lane_t [1:0]             ch_lane  [QUO_W+1];

    // Final stage
    logic [QUO_W-1:0]        q_x, q_y;
    logic signed [43:0]      sum_x, sum_y;
    logic signed [31:0]      sat_x, sat_y;
    logic signed [31:0]      rej_val;
    logic                    done_reg;
    res_t                    res_reg, res_next;

    assign busy = 1'b0;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_height_reg    <= EYE_HEIGHT_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            near_limit_reg    <= NEAR_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EYE_HEIGHT:    eye_height_reg    <= cfg_data;
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[11:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[11:0];
                CFG_NEAR_LIMIT:    near_limit_reg    <= cfg_data[30:0];
                default:           ;
            endcase
        end
    end

    // Advance valid flags of the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Near test, depth output and ratio numerators
    always_comb
    begin
        vis_next = cz_reg > $signed({5'b0, near_limit_reg, 14'b0});
        if (!vis_next)
            depth_next = '0;
        else if (|cz_reg[DEN_W-1:45])
            depth_next = '1;
        else
            depth_next = cz_reg[44:14];
        nx_next = NUM_W'(cx_reg) * NUM_W'($signed({1'b0, screen_height_reg}));
        dysh    = 46'(dy3_reg) * 46'($signed({1'b0, screen_height_reg}));
        ny_next = (-NUM_W'(dysh)) <<< DIR_FRAC;
    end

    // Split numerators into sign, magnitude and first partial remainder
    always_comb
    begin
        mag_x = nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        mag_y = ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
        if (!vis_reg)
        begin
            mag_x = '0;
            mag_y = '0;
        end
        hi_x  = mag_x >> HI_SHIFT;
        hi_y  = mag_y >> HI_SHIFT;
        ovf_x = hi_x >= NUM_W'(den4_reg);
        ovf_y = hi_y >= NUM_W'(den4_reg);
        lane5_next[0].rem = ovf_x ? '0 : hi_x[DEN_W-1:0];
        lane5_next[1].rem = ovf_y ? '0 : hi_y[DEN_W-1:0];
        lane5_next[0].low = mag_x[QUO_W-1:0] << COORD_FRAC_BITS;
        lane5_next[1].low = mag_y[QUO_W-1:0] << COORD_FRAC_BITS;
        lane5_next[0].quo = '0;
        lane5_next[1].quo = '0;
        side5_next.vis    = vis_reg;
        side5_next.depth  = depth_reg;
        side5_next.neg_x  = nx_reg[NUM_W-1];
        side5_next.neg_y  = ny_reg[NUM_W-1];
        side5_next.ovf_x  = ovf_x;
        side5_next.ovf_y  = ovf_y;
    end

    // Hold the data of the arithmetic stages
    always_ff @(posedge clk)
    begin
        dx_reg    <= 33'(vtx.vertex_x) - 33'(vtx.eye_x);
        dz_reg    <= 33'(vtx.vertex_z) - 33'(vtx.eye_z);
        dy1_reg   <= 33'(vtx.vertex_height) - 33'(eye_height_reg);
        ux_reg    <= vtx.dir_x;
        uz_reg    <= vtx.dir_z;

        p_xx_reg  <= 49'(dx_reg) * 49'(ux_reg);
        p_xz_reg  <= 49'(dx_reg) * 49'(uz_reg);
        p_zx_reg  <= 49'(dz_reg) * 49'(ux_reg);
        p_zz_reg  <= 49'(dz_reg) * 49'(uz_reg);
        dy2_reg   <= dy1_reg;

        cx_reg    <= DEN_W'(p_zx_reg) - DEN_W'(p_xz_reg);
        cz_reg    <= DEN_W'(p_xx_reg) + DEN_W'(p_zz_reg);
        dy3_reg   <= dy2_reg;

        vis_reg   <= vis_next;
        depth_reg <= depth_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        den4_reg  <= vis_next ? DEN_W'(cz_reg) : DEN_W'(1);

        den5_reg  <= den4_reg;
        side5_reg <= side5_next;
        lane5_reg <= lane5_next;
    end

    // Divider chain, one quotient bit per cell
    assign ch_valid[0] = s5_valid_reg;
    assign ch_den[0]   = den5_reg;
    assign ch_side[0]  = side5_reg;
    assign ch_lane[0]  = lane5_reg;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        pvp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ch_valid[i]),
            .in_den    (ch_den[i]),
            .in_side   (ch_side[i]),
            .in_lane   (ch_lane[i]),
            .out_valid (ch_valid[i+1]),
            .out_den   (ch_den[i+1]),
            .out_side  (ch_side[i+1]),
            .out_lane  (ch_lane[i+1])
        );
    end

    // Clamp terms, add screen centers and saturate; rejected items get the reject pattern
    always_comb
    begin
        q_x = ch_lane[QUO_W][0].quo;
        q_y = ch_lane[QUO_W][1].quo;
        if (ch_side[QUO_W].ovf_x || (q_x[QUO_W-1] && |q_x[QUO_W-2:0]))
            q_x = {1'b1, {(QUO_W-1){1'b0}}};
        if (ch_side[QUO_W].ovf_y || (q_y[QUO_W-1] && |q_y[QUO_W-2:0]))
            q_y = {1'b1, {(QUO_W-1){1'b0}}};
        sum_x = (ch_side[QUO_W].neg_x ? -44'(q_x) : 44'(q_x))
              + $signed(44'(screen_width_reg) << (COORD_FRAC_BITS - 1));
        sum_y = (ch_side[QUO_W].neg_y ? -44'(q_y) : 44'(q_y))
              + $signed(44'(screen_height_reg) << (COORD_FRAC_BITS - 1));
        if (sum_x > 44'sh7FFFFFFF)
            sat_x = 32'sh7FFFFFFF;
        else if (sum_x < -44'sh80000000)
            sat_x = -32'sh80000000;
        else
            sat_x = sum_x[31:0];
        if (sum_y > 44'sh7FFFFFFF)
            sat_y = 32'sh7FFFFFFF;
        else if (sum_y < -44'sh80000000)
            sat_y = -32'sh80000000;
        else
            sat_y = sum_y[31:0];
        rej_val = ~((32'sd1 <<< COORD_FRAC_BITS) - 32'sd1);
        if (ch_side[QUO_W].vis)
        begin
            res_next.screen_x = sat_x;
            res_next.screen_y = sat_y;
            res_next.depth    = ch_side[QUO_W].depth;
            res_next.visible  = 1'b1;
        end
        else
        begin
            res_next.screen_x = rej_val;
            res_next.screen_y = rej_val;
            res_next.depth    = '0;
            res_next.visible  = 1'b0;
        end
    end

    // Strobe the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ch_valid[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

    // Every accepted item strobes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item did not complete at fixed latency");
    // Rejected items carry the reject pattern
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.visible) |-> (res.depth == '0 && res.screen_x == res.screen_y))
        else $error("rejected item has bad fields");
    // Visible items never leave with negative depth in the pipe's divisor
    a_vis_den: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && side5_reg.vis) |-> den5_reg[DEN_W-1] == 1'b0)
        else $error("visible item with negative depth");

endmodule

// ===== tb/sv/perspective_vertex_projection_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_vertex_projection_tb: self-checking bench of the vertex projector
// Feeds directed and random vertex items through a gapped driver and compares
// each done strobe against a bit-exact projection computed in the bench.
// Register settings change between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module perspective_vertex_projection_tb;
    import pvp_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 47;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [40:0] TERM_MAX = 41'h100_0000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    vtx_t        vtx = '0;
    logic        done;
    res_t        res;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_EYE_HEIGHT;
    logic [31:0] cfg_data = '0;

    // Bench copy of the registers
    logic signed [31:0] m_eye_height = EYE_HEIGHT_RST;
    logic [11:0]        m_width = SCREEN_WIDTH_RST;
    logic [11:0]        m_height = SCREEN_HEIGHT_RST;
    logic [30:0]        m_near = NEAR_LIMIT_RST;

    vtx_t   pending_items[$];
    res_t   projected_results[$];
    int     mismatches = 0;
    longint cycles = 0;
    int     gap_left = 0;

    perspective_vertex_projection dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .vtx(vtx),
        .done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // num * 2^F / den, truncated toward zero and clamped to +-2^40
    function automatic logic signed [63:0] ratio_term(logic signed [63:0] num,
                                                      logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        logic [127:0] full;
        mag = num < 0 ? -num : num;
        q = mag / den;
        if (q > (TERM_MAX >> FRAC))
            full = 128'(TERM_MAX);
        else
            full = ({64'd0, mag} << FRAC) / den;
        if (full > TERM_MAX)
            full = 128'(TERM_MAX);
        return num < 0 ? -$signed(full[63:0]) : $signed(full[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic res_t project_vertex(vtx_t v);
        logic signed [63:0] dx, dz, dy, cx, cz, tx, ty;
        logic [63:0] dep;
        res_t r;
        dx = 64'(v.vertex_x) - 64'(v.eye_x);
        dz = 64'(v.vertex_z) - 64'(v.eye_z);
        dy = 64'(v.vertex_height) - 64'(m_eye_height);
        cx = dx * -64'(v.dir_z) + dz * 64'(v.dir_x);
        cz = dx * 64'(v.dir_x) + dz * 64'(v.dir_z);
        // Reject at or behind the near limit
        if (cz <= $signed({33'd0, m_near} << 14)) begin
            r.screen_x = -(32'sd1 <<< FRAC);
            r.screen_y = -(32'sd1 <<< FRAC);
            r.depth = '0;
            r.visible = 1'b0;
            return r;
        end
        dep = cz >>> 14;
        if (dep > 64'h7fffffff)
            dep = 64'h7fffffff;
        tx = ratio_term(cx * $signed({52'd0, m_height}), cz);
        ty = ratio_term(-dy * 64'sd16384 * $signed({52'd0, m_height}), cz);
        tx += $signed({52'd0, m_width}) <<< (FRAC - 1);
        ty += $signed({52'd0, m_height}) <<< (FRAC - 1);
        r.screen_x = clamp32(tx);
        r.screen_y = clamp32(ty);
        r.depth = dep[30:0];
        r.visible = 1'b1;
        return r;
    endfunction

    // Driver: pull items from the pending queue with random gaps
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n) begin
            if (start && !busy) begin
                projected_results.push_back(project_vertex(vtx));
            end
            if (start && busy) begin
                // hold the current item
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                vtx <= pending_items.pop_front();
                start <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                            : $urandom_range(0, 3);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest projection
    always @(posedge clk) begin
        res_t want;
        if (rst_n && done) begin
            if (projected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %h", res);
            end else begin
                want = projected_results.pop_front();
                if (res.screen_x !== want.screen_x || res.screen_y !== want.screen_y ||
                    res.depth !== want.depth || res.visible !== want.visible) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp x=%h y=%h d=%h v=%b got x=%h y=%h d=%h v=%b",
                                 want.screen_x, want.screen_y, want.depth, want.visible,
                                 res.screen_x, res.screen_y, res.depth, res.visible);
                end
            end
        end
    end

    // Timeout
    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic vtx_t random_vertex();
        vtx_t v;
        int mode;
        mode = $urandom_range(0, 9);
        v.vertex_x = $urandom;
        v.vertex_height = $urandom;
        v.vertex_z = $urandom;
        v.eye_x = $urandom;
        v.eye_z = $urandom;
        v.dir_x = 16'($urandom);
        v.dir_z = 16'($urandom);
        if (mode < 7) begin
            // mostly a sane scene: small offsets, unit-ish direction
            v.eye_x = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            v.eye_z = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            v.vertex_x = v.eye_x + ($signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000);
            v.vertex_z = v.eye_z + ($signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000);
            v.vertex_height = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            v.dir_x = 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
            v.dir_z = 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
        end
        return v;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_EYE_HEIGHT:    m_eye_height = data;
            CFG_SCREEN_WIDTH:  m_width = data[11:0];
            CFG_SCREEN_HEIGHT: m_height = data[11:0];
            CFG_NEAR_LIMIT:    m_near = data[30:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipe();
        while (pending_items.size() > 0 || start || projected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic add_vertex(input logic signed [31:0] x, input logic signed [31:0] h,
                              input logic signed [31:0] z, input logic signed [31:0] ex,
                              input logic signed [31:0] ez, input logic signed [15:0] ux,
                              input logic signed [15:0] uz);
        vtx_t v;
        v.vertex_x = x; v.vertex_height = h; v.vertex_z = z;
        v.eye_x = ex; v.eye_z = ez; v.dir_x = ux; v.dir_z = uz;
        pending_items.push_back(v);
    endtask

    initial begin
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: straight ahead, behind, at near limit, extremes
        add_vertex(0, 0, 32'sh000a_0000, 0, 0, 0, 16'sd16384);
        add_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0005_0000, 0, 0, 0, 16'sd16384);
        add_vertex(0, 0, -32'sh000a_0000, 0, 0, 0, 16'sd16384);
        add_vertex(0, 0, 32'sd6554, 0, 0, 0, 16'sd16384);
        add_vertex(0, 0, 32'sd6555, 0, 0, 0, 16'sd16384);
        add_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh80000000, 32'sh80000000, 16'sh7fff, 16'sh7fff);
        add_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh7fffffff, 32'sh7fffffff, 16'sh8000, 16'sh8000);
        add_vertex(32'sh7fffffff, 32'sh80000000, 32'sh0000_8000, 0, 0, 16'sh8000, 16'sh7fff);
        add_vertex(32'sh4000_0000, 0, 32'sd7000, 0, 0, 0, 16'sd16384);
        add_vertex(0, 32'sh7fff_0000, 32'sd7000, 0, 0, 0, 16'sd16384);
        add_vertex(32'sh0010_0000, 0, 0, 0, 0, 16'sd16384, 0);
        add_vertex(0, 0, 0, 0, 0, 0, 0);
        add_vertex(-1, -1, -1, -1, -1, -1, -1);
        drain_pipe();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_EYE_HEIGHT, 32'h7fffffff);
                    write_reg(CFG_SCREEN_WIDTH, 32'd4095);
                    write_reg(CFG_SCREEN_HEIGHT, 32'd4095);
                    write_reg(CFG_NEAR_LIMIT, 32'h0);
                end
                1: begin
                    write_reg(CFG_EYE_HEIGHT, 32'h80000000);
                    write_reg(CFG_SCREEN_WIDTH, 32'd1);
                    write_reg(CFG_SCREEN_HEIGHT, 32'd1);
                    write_reg(CFG_NEAR_LIMIT, 32'h7fffffff);
                end
                2: begin
                    write_reg(CFG_SCREEN_WIDTH, 32'h0);
                    write_reg(CFG_SCREEN_HEIGHT, 32'hfffff000);
                    write_reg(CFG_NEAR_LIMIT, 32'hffffffff);
                    write_reg(CFG_NEAR_LIMIT, 32'd1);
                end
                default: begin
                    write_reg(CFG_EYE_HEIGHT, $urandom);
                    write_reg(CFG_SCREEN_WIDTH, $urandom);
                    write_reg(CFG_SCREEN_HEIGHT, $urandom);
                    write_reg(CFG_NEAR_LIMIT, $urandom_range(0, 32'h0010_0000));
                end
            endcase
            repeat (125) pending_items.push_back(random_vertex());
            // hold the sender off until everything is back once per phase
            drain_pipe();
        end

        if (mismatches == 0 && projected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/pvp_pkg.sv
rtl/pvp_div_cell.sv
rtl/perspective_vertex_projection.sv
tb/sv/perspective_vertex_projection_tb.sv
